@@ src/pidff_pkg.sv @@
// ----------------------------------------------------------------------------
// pidff_pkg: shared types and constants
// Widths, reset values, register codes and the queue record of the servo
// axis PID step.
// ----------------------------------------------------------------------------
package pidff_pkg;

  // field widths
  localparam int GAIN_W     = 48;  // Q16.32 gains
  localparam int SMP_W      = 16;  // Q12.4 samples
  localparam int ERR_W      = SMP_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int INTEG_W    = 32;
  localparam int DB_W       = 16;
  localparam int CMP_W      = 12;
  localparam int FRAC_POS   = 20;
  localparam int SERVO_W    = CMP_W + FRAC_POS;

  // multiplier split: gain = hi * 2^GLO_W + lo
  localparam int OPND_W     = INTEG_W;
  localparam int GLO_W      = 24;
  localparam int GHI_W      = GAIN_W - GLO_W;
  localparam int PLO_W      = GLO_W + 1 + OPND_W;
  localparam int PHI_W      = GHI_W + OPND_W;
  localparam int SLO_W      = PLO_W + 2;
  localparam int SHI_W      = PHI_W + 2;
  localparam int SUM_W      = SHI_W + GLO_W + 1;
  localparam int ACC_SHIFT  = 16;  // Q.36 -> Q.20
  localparam int SH_W       = SUM_W - ACC_SHIFT;
  localparam int DELTA_W    = 42;
  localparam int POSN_W     = DELTA_W + 1;
  localparam int NUM_TERMS  = 4;

  localparam int DECAY_W     = 8;
  localparam int DECAY_SHIFT = 8;
  localparam logic [DECAY_W-1:0] DECAY_NUM = 8'd179;

  localparam logic signed [DELTA_W-1:0] DELTA_LIM = 42'sh100_0000_0000;
  localparam logic signed [DELTA_W-1:0] DELTA_NEG = -DELTA_LIM;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;
  localparam int QUEUE_DEPTH = 4;

  // reset values
  localparam logic signed [GAIN_W-1:0] KP_RST  = 48'sd858993;
  localparam logic signed [GAIN_W-1:0] KI_RST  = 48'sd30;
  localparam logic signed [GAIN_W-1:0] KD_RST  = 48'sh0001_0000_0000;
  localparam logic signed [GAIN_W-1:0] KFF_RST = 48'sd7731;
  localparam logic [DB_W-1:0]  DB_RST    = 16'd19;
  localparam logic [CMP_W-1:0] OMIN_RST  = 12'd500;
  localparam logic [CMP_W-1:0] OMAX_RST  = 12'd2500;
  localparam logic [CMP_W-1:0] START_RST = 12'd2350;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP, REG_KI, REG_KD, REG_KFF, REG_DEADBAND, REG_OUT_MIN, REG_OUT_MAX, REG_START
  } cfg_reg_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic signed [GAIN_W-1:0] kff;
    logic [DB_W-1:0]          deadband;
    logic [CMP_W-1:0]         out_min;
    logic [CMP_W-1:0]         out_max;
    logic [CMP_W-1:0]         start_pos;
  } cfg_t;

  // classified step, front to back
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;     // error after deadband zeroing
    logic signed [DIFF_W-1:0]  ddiff;   // error minus last error
    logic signed [INTEG_W-1:0] integ;   // updated integral
    logic signed [ERR_W-1:0]   vel;     // target change
    logic                      reload;
    logic                      inband;
  } cmd_t;

endpackage

@@ src/pidff_stream_if.sv @@
// ----------------------------------------------------------------------------
// pidff_stream_if: request channels
// Valid/ready channels for the sample requests and the compare results.
// ----------------------------------------------------------------------------
interface pidff_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [pidff_pkg::SMP_W-1:0]       measured;
  logic signed [pidff_pkg::SMP_W-1:0]       target;
  logic                                     reload_position;

  modport source (output valid, output measured, output target, output reload_position,
                  input ready);
  modport sink   (input valid, input measured, input target, input reload_position,
                  output ready);
endinterface

interface pidff_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [pidff_pkg::CMP_W-1:0]              compare_value;
  logic                                     in_deadband;

  modport source (output valid, output compare_value, output in_deadband, input ready);
  modport sink   (input valid, input compare_value, input in_deadband, output ready);
endinterface

@@ src/pidff_front.sv @@
// ----------------------------------------------------------------------------
// pidff_front: request intake
// Forms error and target change, applies the deadband, updates the integral
// and pushes one record per request into the queue.
// ----------------------------------------------------------------------------
module pidff_front (
  input  logic                         clk,
  input  logic                         rst_n,
  pidff_in_if.sink                     in_if,
  input  logic [pidff_pkg::DB_W-1:0]   deadband,
  input  logic                         q_full,
  output logic                         q_push,
  output pidff_pkg::cmd_t              q_cmd
);
  import pidff_pkg::*;

  logic signed [SMP_W-1:0]   last_tgt_r,  last_tgt_nxt;
  logic signed [ERR_W-1:0]   last_err_r,  last_err_nxt;
  logic signed [INTEG_W-1:0] integ_r,     integ_nxt;

  logic signed [ERR_W-1:0]   err, err_z, vel;
  logic [ERR_W-1:0]          err_mag;
  logic                      inband;
  logic [INTEG_W-1:0]        i_mag, decay_mag;
  logic [INTEG_W+DECAY_W-1:0] decay_prod;
  logic signed [INTEG_W-1:0] decayed, sat_sum;
  logic signed [INTEG_W:0]   sum_w;

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  always_comb begin
    err     = ERR_W'(in_if.target) - ERR_W'(in_if.measured);
    vel     = ERR_W'(in_if.target) - ERR_W'(last_tgt_r);
    err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    inband  = err_mag < {1'b0, deadband};
    err_z   = inband ? '0 : err;

    // decay keeps the sign and truncates the magnitude
    i_mag      = integ_r[INTEG_W-1] ? INTEG_W'(-integ_r) : INTEG_W'(integ_r);
    decay_prod = (INTEG_W+DECAY_W)'(i_mag) * (INTEG_W+DECAY_W)'(DECAY_NUM);
    decay_mag  = decay_prod[DECAY_SHIFT +: INTEG_W];
    decayed    = integ_r[INTEG_W-1] ? -$signed(decay_mag) : $signed(decay_mag);

    sum_w = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(err);
    if (sum_w[INTEG_W] != sum_w[INTEG_W-1]) begin
      sat_sum = sum_w[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      sat_sum = sum_w[INTEG_W-1:0];
    end

    integ_nxt    = inband ? decayed : sat_sum;
    last_err_nxt = err_z;
    last_tgt_nxt = in_if.target;

    q_cmd.err    = err_z;
    q_cmd.ddiff  = DIFF_W'(err_z) - DIFF_W'(last_err_r);
    q_cmd.integ  = integ_nxt;
    q_cmd.vel    = vel;
    q_cmd.reload = in_if.reload_position;
    q_cmd.inband = inband;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tgt_r <= '0;
      last_err_r <= '0;
      integ_r    <= '0;
    end else if (q_push) begin
      last_tgt_r <= last_tgt_nxt;
      last_err_r <= last_err_nxt;
      integ_r    <= integ_nxt;
    end
  end

endmodule

@@ src/pidff_fifo.sv @@
// ----------------------------------------------------------------------------
// pidff_fifo: step queue
// Small first-in first-out queue between intake and arithmetic.
// ----------------------------------------------------------------------------
module pidff_fifo #(
  parameter int DEPTH = pidff_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pidff_pkg::cmd_t din,
  input  logic            pop,
  output pidff_pkg::cmd_t dout,
  output logic            full,
  output logic            not_empty
);
  import pidff_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign dout      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ src/pidff_back.sv @@
// ----------------------------------------------------------------------------
// pidff_back: PID arithmetic and position update
// Four stages: split partial products, partial sums, shift and limit,
// then position update with clamp into the result register.
// ----------------------------------------------------------------------------
module pidff_back (
  input  logic            clk,
  input  logic            rst_n,
  input  pidff_pkg::cfg_t cfg,
  input  pidff_pkg::cmd_t q_cmd,
  input  logic            q_valid,
  output logic            q_pop,
  pidff_out_if.source     out_if
);
  import pidff_pkg::*;

  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;

  // stage 1
  logic signed [GAIN_W-1:0] gain [NUM_TERMS];
  logic signed [OPND_W-1:0] opnd [NUM_TERMS];
  logic signed [PLO_W-1:0]  plo  [NUM_TERMS];
  logic signed [PHI_W-1:0]  phi  [NUM_TERMS];
  logic signed [PLO_W-1:0]  plo_r [NUM_TERMS];
  logic signed [PHI_W-1:0]  phi_r [NUM_TERMS];
  logic                     rl1_r, ib1_r;

  // stage 2
  logic signed [SLO_W-1:0]  slo, slo_r;
  logic signed [SHI_W-1:0]  shi, shi_r;
  logic                     rl2_r, ib2_r;

  // stage 3
  logic signed [SUM_W-1:0]   total;
  logic signed [SH_W-1:0]    sh;
  logic signed [DELTA_W-1:0] delta, delta_r;
  logic                      rl3_r, ib3_r;

  // stage 4
  logic [SERVO_W-1:0]       servo_r, servo_nxt, base;
  logic signed [POSN_W-1:0] pos, hi_b, lo_b, pos_cl;
  logic [CMP_W-1:0]         cmp_r;
  logic                     ib4_r;

  assign en4   = !v4_r || out_if.ready;
  assign en3   = !v3_r || en4;
  assign en2   = !v2_r || en3;
  assign en1   = !v1_r || en2;
  assign q_pop = q_valid && en1;

  assign out_if.valid         = v4_r;
  assign out_if.compare_value = cmp_r;
  assign out_if.in_deadband   = ib4_r;

  always_comb begin
    gain[0] = cfg.kp;   opnd[0] = OPND_W'(q_cmd.err);
    gain[1] = cfg.kd;   opnd[1] = OPND_W'(q_cmd.ddiff);
    gain[2] = cfg.ki;   opnd[2] = OPND_W'(q_cmd.integ);
    gain[3] = cfg.kff;  opnd[3] = OPND_W'(q_cmd.vel);
    for (int k = 0; k < NUM_TERMS; k++) begin
      plo[k] = PLO_W'($signed({1'b0, gain[k][GLO_W-1:0]})) * PLO_W'(opnd[k]);
      phi[k] = PHI_W'($signed(gain[k][GAIN_W-1:GLO_W])) * PHI_W'(opnd[k]);
    end
  end

  always_comb begin
    slo = '0;
    shi = '0;
    for (int k = 0; k < NUM_TERMS; k++) begin
      slo = slo + SLO_W'(plo_r[k]);
      shi = shi + SHI_W'(phi_r[k]);
    end
  end

  always_comb begin
    total = (SUM_W'(shi_r) <<< GLO_W) + SUM_W'(slo_r);
    sh    = total[SUM_W-1:ACC_SHIFT];   // floor shift
    if (sh > SH_W'(DELTA_LIM)) begin
      delta = DELTA_LIM;
    end else if (sh < SH_W'(DELTA_NEG)) begin
      delta = DELTA_NEG;
    end else begin
      delta = sh[DELTA_W-1:0];
    end
  end

  always_comb begin
    base   = rl3_r ? {cfg.start_pos, {FRAC_POS{1'b0}}} : servo_r;
    pos    = POSN_W'($signed({1'b0, base})) + POSN_W'(delta_r);
    hi_b   = POSN_W'($signed({1'b0, cfg.out_max, {FRAC_POS{1'b0}}}));
    lo_b   = POSN_W'($signed({1'b0, cfg.out_min, {FRAC_POS{1'b0}}}));
    if (pos > hi_b) begin
      pos_cl = hi_b;
    end else if (pos < lo_b) begin
      pos_cl = lo_b;
    end else begin
      pos_cl = pos;
    end
    servo_nxt = pos_cl[SERVO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      servo_r <= {START_RST, {FRAC_POS{1'b0}}};
    end else begin
      if (en1) v1_r <= q_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en4 && v3_r) servo_r <= servo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        plo_r[k] <= plo[k];
        phi_r[k] <= phi[k];
      end
      rl1_r <= q_cmd.reload;
      ib1_r <= q_cmd.inband;
    end
    if (en2 && v1_r) begin
      slo_r <= slo;
      shi_r <= shi;
      rl2_r <= rl1_r;
      ib2_r <= ib1_r;
    end
    if (en3 && v2_r) begin
      delta_r <= delta;
      rl3_r   <= rl2_r;
      ib3_r   <= ib2_r;
    end
    if (en4 && v3_r) begin
      cmp_r <= servo_nxt[SERVO_W-1:FRAC_POS];
      ib4_r <= ib3_r;
    end
  end

endmodule

@@ src/pid_servo_axis_with_feedforward_unit.sv @@
// ----------------------------------------------------------------------------
// pid_servo_axis_with_feedforward_unit: servo axis PID step
// PID with deadband, integral decay and target feedforward; one compare
// value per measured/target request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in_if   | sink      | valid/ready       | measured, target, reload_position
//  out_if  | source    | valid/ready       | compare_value, in_deadband
//  cfg_*   | sink      | cfg_we, no ready  | cfg_index, cfg_wdata
//
//  One request per cycle sustained while out_if.ready holds; each
//  request is written to the queue, then passes four arithmetic stages.
//  The rate is held by two loops closed through a single register each:
//  integral/last error in intake, servo position add and clamp in the last stage.
//  Reset (synchronous, rst_n low) restores default gains and limits, clears
//  the history and sets the position to the default start.
//  A stalled result fills the back stages, then the queue; only then does
//  in_if.ready drop.
// ----------------------------------------------------------------------------
module pid_servo_axis_with_feedforward_unit #(
  parameter int QDEPTH = pidff_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pidff_in_if.sink                           in_if,
  pidff_out_if.source                        out_if,
  input  logic                               cfg_we,
  input  logic [pidff_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pidff_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pidff_pkg::*;

  cfg_t cfg_r;
  cmd_t push_cmd, pop_cmd;
  logic q_push, q_pop, q_full, q_valid;

  // register file: the user must write it only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp        <= KP_RST;
      cfg_r.ki        <= KI_RST;
      cfg_r.kd        <= KD_RST;
      cfg_r.kff       <= KFF_RST;
      cfg_r.deadband  <= DB_RST;
      cfg_r.out_min   <= OMIN_RST;
      cfg_r.out_max   <= OMAX_RST;
      cfg_r.start_pos <= START_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KP:       cfg_r.kp        <= $signed(cfg_wdata[GAIN_W-1:0]);
        REG_KI:       cfg_r.ki        <= $signed(cfg_wdata[GAIN_W-1:0]);
        REG_KD:       cfg_r.kd        <= $signed(cfg_wdata[GAIN_W-1:0]);
        REG_KFF:      cfg_r.kff       <= $signed(cfg_wdata[GAIN_W-1:0]);
        REG_DEADBAND: cfg_r.deadband  <= cfg_wdata[DB_W-1:0];
        REG_OUT_MIN:  cfg_r.out_min   <= cfg_wdata[CMP_W-1:0];
        REG_OUT_MAX:  cfg_r.out_max   <= cfg_wdata[CMP_W-1:0];
        REG_START:    cfg_r.start_pos <= cfg_wdata[CMP_W-1:0];
      endcase
    end
  end

  // intake: deadband, integral and history
  pidff_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .deadband (cfg_r.deadband),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // decoupling queue
  pidff_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (push_cmd),
    .pop       (q_pop),
    .dout      (pop_cmd),
    .full      (q_full),
    .not_empty (q_valid)
  );

  // gains, sum, limit, position and result register
  pidff_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_cmd   (pop_cmd),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule
